>>> src/deq_pkg.sv
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int FILL_W = 5;

    // operation code carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    // status code carried in m_axis_tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

endpackage

>>> src/double_ended_queue_core.sv
// double-ended queue of signed 32-bit values in a ring buffer of DEPTH slots
//
// input channel (s_axis): one request per item, the operation in tuser and
// the value to push in tdata; pops ignore tdata
// output channel (m_axis): exactly one result per request, in request order:
// popped value and fill count in tdata, status in tuser
//
// a push writes its slot in the cycle it is accepted and its result is valid
// in the next cycle, so pushes run at one request per cycle while the receiver takes every result
// a successful pop reads the slot ram, whose read port is registered; the
// read data goes on to the output register in state S_READ, and the input
// stays closed for the read, so the next request waits for that result
// failed pops and pushes (underflow, overflow) give their result in the next cycle
//
// a single output register holds the result; a new request is taken while
// that result is being drained, so a stalled receiver holds the input only
// once the output register is occupied and not taken
// reset empties the queue at once: front pointer and count go to zero, the
// slot contents are left as they are and are never read before written
module double_ended_queue_core import deq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] op

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] popped, [36:32] fill, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    typedef enum logic {
        S_READY,
        S_READ
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]        r_front, n_front;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_popped, n_out_popped;
    t_status                  r_out_status, n_out_status;
    logic [FILL_W-1:0]        r_out_fill, n_out_fill;

    logic                     s_accept;
    logic                     out_free;
    t_op                      req_op;
    logic signed [DATA_W-1:0] req_value;

    logic [SUM_W-1:0]         sum_tail;     // front + count
    logic [SUM_W-1:0]         sum_back;     // front + count - 1
    logic [ADDR_W-1:0]        tail_addr;    // first free slot behind the back
    logic [ADDR_W-1:0]        back_addr;    // slot of the back entry
    logic [ADDR_W-1:0]        front_prev;   // slot ahead of the front entry

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    assign req_op    = t_op'(s_axis_tuser);
    assign req_value = s_axis_tdata;

    // output register drains this cycle or is empty
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_READY) && out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ring positions, front < DEPTH and count <= DEPTH so one subtract wraps
    always_comb begin
        sum_tail = SUM_W'(r_front) + SUM_W'(r_count);
        sum_back = sum_tail - SUM_W'(1);
        if (sum_tail >= SUM_DEPTH) begin
            tail_addr = ADDR_W'(sum_tail - SUM_DEPTH);
        end else begin
            tail_addr = ADDR_W'(sum_tail);
        end
        if (sum_back >= SUM_DEPTH) begin
            back_addr = ADDR_W'(sum_back - SUM_DEPTH);
        end else begin
            back_addr = ADDR_W'(sum_back);
        end
        if (r_front == '0) begin
            front_prev = ADDR_LAST;
        end else begin
            front_prev = r_front - ADDR_W'(1);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_popped = r_out_popped;
        n_out_status = r_out_status;
        n_out_fill   = r_out_fill;
        wr_en        = 1'b0;
        wr_addr      = tail_addr;
        rd_en        = 1'b0;
        rd_addr      = r_front;

        case (r_state)
            S_READ: begin
                // slot data arrives, output register is empty by construction
                n_out_valid  = 1'b1;
                n_out_popped = rd_data;
                n_state      = S_READY;
            end
            default: begin
                if (s_accept) begin
                    n_out_popped = '0;
                    n_out_status = ST_OK;
                    case (req_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (r_count == CNT_FULL) begin
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (req_op == OP_PUSH_FRONT) begin
                                    wr_addr = front_prev;
                                    n_front = front_prev;
                                end
                            end
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_out_status = ST_UNDERFLOW;
                                n_out_valid  = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - CNT_W'(1);
                                n_state = S_READ;
                                if (req_op == OP_POP_FRONT) begin
                                    if (r_front == ADDR_LAST) begin
                                        n_front = '0;
                                    end else begin
                                        n_front = r_front + ADDR_W'(1);
                                    end
                                end else begin
                                    rd_addr = back_addr;
                                end
                            end
                        end
                    endcase
                    n_out_fill = FILL_W'(n_count);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READY;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_popped <= n_out_popped;
        r_out_status <= n_out_status;
        r_out_fill   <= n_out_fill;
    end

    deq_slots #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (req_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_fill, r_out_popped};
    assign m_axis_tuser  = r_out_status;

    // count never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count above depth");

    // while a pop read is in flight the output register is empty
    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("output register occupied during slot read");

    // a pop read always delivers a result in the next cycle
    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_state == S_READY))
        else $error("pop read did not deliver a result");

    // a pop on a non-empty queue starts a read and lowers the count
    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tuser[1] && r_count != '0)
            |=> (r_state == S_READ && r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not start a slot read");

    // no write to the slots while a read is in flight
    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !wr_en)
        else $error("slot write during pop read");

endmodule

>>> src/deq_slots.sv
module deq_slots import deq_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [ADDR_W-1:0]        i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [ADDR_W-1:0]        i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
